### hdl/calendar_clock_counter_unit_macros.svh
// Assertion helpers for the calendar clock counter checker.
// Every macro samples on the rising edge of aclk.
`ifndef CALENDAR_CLOCK_COUNTER_UNIT_MACROS_SVH
`define CALENDAR_CLOCK_COUNTER_UNIT_MACROS_SVH

// Property checked only while aresetn is high.
`define RCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Property checked on every edge, reset included.
`define RCC_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hdl/rcc_pkg.sv
// Shared types, field widths and calendar helpers for the calendar clock counter.
// No dependencies; every module in the project uses this package.
package rcc_pkg;

    localparam int YEAR_BITS_DEF   = 14;
    localparam int AMOUNT_BITS_DEF = 20;

    localparam int REQ_W  = 3;
    localparam int SEC_W  = 6;
    localparam int MIN_W  = 6;
    localparam int HOUR_W = 5;
    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int DATE_FIX_BITS = SEC_W + MIN_W + HOUR_W + DAY_W + MON_W;
    localparam int FLAG_BITS     = 3;

    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN  = 32'd60;

    localparam int YEAR_RESET = 2000;

    localparam logic [SEC_W-1:0]  SEC_MAX  = 6'd59;
    localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;
    localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;
    localparam logic [DAY_W-1:0]  DAY_MIN  = 5'd1;
    localparam logic [DAY_W-1:0]  DAY_MAX  = 5'd31;
    localparam logic [MON_W-1:0]  MON_JAN  = 4'd1;
    localparam logic [MON_W-1:0]  MON_FEB  = 4'd2;
    localparam logic [MON_W-1:0]  MON_APR  = 4'd4;
    localparam logic [MON_W-1:0]  MON_JUN  = 4'd6;
    localparam logic [MON_W-1:0]  MON_SEP  = 4'd9;
    localparam logic [MON_W-1:0]  MON_NOV  = 4'd11;
    localparam logic [MON_W-1:0]  MON_DEC  = 4'd12;

    // Step levels of the seconds stepper, one bit each
    localparam int LVL_SEC  = 0;
    localparam int LVL_MIN  = 1;
    localparam int LVL_HOUR = 2;
    localparam int LVL_DAY  = 3;
    localparam int LVL_N    = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD    = 3'd0,
        REQ_TICK_UP = 3'd1,
        REQ_TICK_DN = 3'd2,
        REQ_ADD     = 3'd3,
        REQ_SUB     = 3'd4,
        REQ_CMP     = 3'd5
    } req_t;

    typedef struct packed {
        logic load;
        logic clamp;
        logic inc;
        logic dec;
    } cell_ctl_t;

    typedef struct packed {
        logic             valid;
        logic             up;
        logic [LVL_N-1:0] lvl;
    } step_t;

    function automatic logic [DAY_W-1:0] days_in(input logic [MON_W-1:0] m, input logic lp);
        logic [DAY_W-1:0] len;
        case (m)
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            MON_FEB: len = lp ? 5'd29 : 5'd28;
            default: len = DAY_MAX;
        endcase
        return len;
    endfunction

    // Inverse of 25 modulo 2^32; a product with it tests divisibility by 25
    function automatic logic [31:0] inv_mod_25();
        logic [31:0] x;
        x = 32'd25;
        for (int i = 0; i < 4; i++) begin
            x = x * (32'd2 - 32'd25 * x);
        end
        return x;
    endfunction

    localparam logic [31:0] INV25 = inv_mod_25();

endpackage

### hdl/rcc_cell.sv
// One counter cell of the calendar chain: holds one field, takes carry or borrow
// from its lower neighbor and hands its own on. Depends on rcc_pkg.
module rcc_cell #(
    parameter int         W       = 6,
    parameter logic [W-1:0] RST_VAL = '0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rcc_pkg::cell_ctl_t ctl,
    input  logic [W-1:0]       load_val,
    input  logic [W-1:0]       lo,
    input  logic [W-1:0]       hi,
    input  logic [W-1:0]       hi_dn,
    output logic [W-1:0]       value,
    output logic [W-1:0]       value_nxt,
    output logic               carry,
    output logic               borrow
);

    logic [W-1:0] val_reg;
    logic [W-1:0] val_next;
    logic [W-1:0] sat_src;

    always_comb begin
        sat_src = ctl.load ? load_val : val_reg;
        carry   = ctl.inc && (val_reg == hi);
        borrow  = ctl.dec && (val_reg == lo);
        val_next = val_reg;
        if (ctl.load || ctl.clamp) begin
            // saturate into [lo, hi]
            if (sat_src < lo) begin
                val_next = lo;
            end else if (sat_src > hi) begin
                val_next = hi;
            end else begin
                val_next = sat_src;
            end
        end else if (ctl.inc) begin
            val_next = carry ? lo : val_reg + W'(1);
        end else if (ctl.dec) begin
            val_next = borrow ? hi_dn : val_reg - W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= RST_VAL;
        end else begin
            val_reg <= val_next;
        end
    end

    assign value     = val_reg;
    assign value_nxt = val_next;

endmodule

### hdl/rcc_step.sv
// Seconds stepper: holds the remaining amount and picks, each cycle, the largest
// of day, hour, minute or second that still fits. Depends on rcc_pkg.
module rcc_step #(
    parameter int AMOUNT_BITS = rcc_pkg::AMOUNT_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic                   start_up,
    input  logic [AMOUNT_BITS-1:0] start_amt,
    input  logic                   advance,
    output rcc_pkg::step_t         step,
    output logic                   last
);
    import rcc_pkg::*;

    logic [AMOUNT_BITS-1:0] rem_reg;
    logic                   up_reg;
    logic [31:0]            rem_w;
    logic [31:0]            sub_amt;
    logic [31:0]            rem_after;
    logic [LVL_N-1:0]       lvl;

    always_comb begin
        rem_w = 32'(rem_reg);
        lvl   = '0;
        if (rem_w >= SECS_PER_DAY) begin
            lvl[LVL_DAY] = 1'b1;
            sub_amt      = SECS_PER_DAY;
        end else if (rem_w >= SECS_PER_HOUR) begin
            lvl[LVL_HOUR] = 1'b1;
            sub_amt       = SECS_PER_HOUR;
        end else if (rem_w >= SECS_PER_MIN) begin
            lvl[LVL_MIN] = 1'b1;
            sub_amt      = SECS_PER_MIN;
        end else begin
            lvl[LVL_SEC] = 1'b1;
            sub_amt      = 32'd1;
        end
        rem_after  = rem_w - sub_amt;
        step.valid = (rem_reg != '0);
        step.up    = up_reg;
        step.lvl   = step.valid ? lvl : '0;
        last       = !step.valid || (rem_after == 32'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            up_reg  <= 1'b0;
        end else if (start) begin
            rem_reg <= start_amt;
            up_reg  <= start_up;
        end else if (advance && step.valid) begin
            rem_reg <= rem_after[AMOUNT_BITS-1:0];
        end
    end

endmodule

### hdl/calendar_clock_counter_unit.sv
// Calendar clock counter top level: six chained counter cells, the seconds
// stepper, compare logic and the result register. Depends on rcc_pkg, rcc_cell, rcc_step.
//
//  channel | ports                     | tuser    | tdata, lowest bits first
//  --------+---------------------------+----------+-----------------------------------------
//  input   | s_tvalid s_tready s_tdata | req_type | amount, second, minute, hour, day,
//          |                           |          | month, year, zero pad
//  result  | m_tvalid m_tready m_tdata | -        | second, minute, hour, day, month, year,
//          |                           |          | is_less, is_equal, year_wrapped, zero pad
//
// Load, compare and unknown requests make no step and ticks make one; each result is then registered.
// Add and subtract make one step of the stepper per part of the amount, none for a zero amount:
// whole days, then hours, minutes and single seconds of the remainder, one step per cycle.
// Reset holds 00:00:00 on January 1 of year 2000 modulo the year range; no clearing pass.
// The last step waits while the result register holds an untaken transfer.
module calendar_clock_counter_unit #(
    parameter int YEAR_BITS   = rcc_pkg::YEAR_BITS_DEF,
    parameter int AMOUNT_BITS = rcc_pkg::AMOUNT_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // amount, in_second, in_minute, in_hour, in_day, in_month, in_year, pad
    input  logic [((AMOUNT_BITS + rcc_pkg::DATE_FIX_BITS + YEAR_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // req_type
    input  logic [rcc_pkg::REQ_W-1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // out_second, out_minute, out_hour, out_day, out_month, out_year,
    // is_less, is_equal, year_wrapped, pad
    output logic [((rcc_pkg::DATE_FIX_BITS + YEAR_BITS + rcc_pkg::FLAG_BITS + 7) / 8) * 8 - 1:0]
        m_tdata
);
    import rcc_pkg::*;

    localparam int M_W = ((DATE_FIX_BITS + YEAR_BITS + FLAG_BITS + 7) / 8) * 8;

    localparam int IN_SEC_LSB  = AMOUNT_BITS;
    localparam int IN_MIN_LSB  = IN_SEC_LSB + SEC_W;
    localparam int IN_HOUR_LSB = IN_MIN_LSB + MIN_W;
    localparam int IN_DAY_LSB  = IN_HOUR_LSB + HOUR_W;
    localparam int IN_MON_LSB  = IN_DAY_LSB + DAY_W;
    localparam int IN_YEAR_LSB = IN_MON_LSB + MON_W;

    localparam logic [YEAR_BITS-1:0] YEAR_RST  = YEAR_BITS'(YEAR_RESET);
    localparam logic [YEAR_BITS-1:0] INV25_Y   = INV25[YEAR_BITS-1:0];
    localparam logic [YEAR_BITS-1:0] DIV25_LIM = YEAR_BITS'(((1 << YEAR_BITS) - 1) / 25);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } state_t;

    // input fields
    req_t                   req;
    logic [AMOUNT_BITS-1:0] amount;
    logic [SEC_W-1:0]       in_second;
    logic [MIN_W-1:0]       in_minute;
    logic [HOUR_W-1:0]      in_hour;
    logic [DAY_W-1:0]       in_day;
    logic [MON_W-1:0]       in_month;
    logic [YEAR_BITS-1:0]   in_year;

    assign req       = req_t'(s_tuser);
    assign amount    = s_tdata[AMOUNT_BITS-1:0];
    assign in_second = s_tdata[IN_SEC_LSB +: SEC_W];
    assign in_minute = s_tdata[IN_MIN_LSB +: MIN_W];
    assign in_hour   = s_tdata[IN_HOUR_LSB +: HOUR_W];
    assign in_day    = s_tdata[IN_DAY_LSB +: DAY_W];
    assign in_month  = s_tdata[IN_MON_LSB +: MON_W];
    assign in_year   = s_tdata[IN_YEAR_LSB +: YEAR_BITS];

    state_t             state_reg, state_next;
    logic               load_reg;
    logic               less_reg;
    logic               eq_reg;
    logic               wrap_reg;
    logic               m_tvalid_reg;
    logic [M_W-1:0]     m_tdata_reg;

    logic               accept;
    logic               out_free;
    logic               advance;
    logic               finish;
    logic               do_step;
    logic               is_load;
    step_t              step;
    logic               last;
    logic [AMOUNT_BITS-1:0] start_amt;
    logic               start_up;

    cell_ctl_t ctl_sec, ctl_min, ctl_hour, ctl_day, ctl_mon, ctl_year;

    logic [SEC_W-1:0]     sec_val, sec_nxt;
    logic [MIN_W-1:0]     min_val, min_nxt;
    logic [HOUR_W-1:0]    hour_val, hour_nxt;
    logic [DAY_W-1:0]     day_val, day_nxt;
    logic [MON_W-1:0]     mon_val, mon_nxt;
    logic [YEAR_BITS-1:0] year_val, year_nxt;
    logic sec_cy, min_cy, hour_cy, day_cy, mon_cy, year_cy;
    logic sec_bw, min_bw, hour_bw, day_bw, mon_bw, year_bw;

    logic [YEAR_BITS-1:0] yr_mul;
    logic                 leap;
    logic [DAY_W-1:0]     day_hi;
    logic [DAY_W-1:0]     day_hi_dn;
    logic [MON_W-1:0]     prev_mon;
    logic                 cmp_less;
    logic                 cmp_eq;
    logic                 wrap_now;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign advance  = (state_reg == ST_BUSY) && (!last || out_free);
    assign finish   = advance && last;
    assign do_step  = advance && step.valid;
    assign is_load  = accept && (req == REQ_LOAD);

    always_comb begin
        start_amt = '0;
        start_up  = 1'b1;
        case (req)
            REQ_TICK_UP: start_amt = AMOUNT_BITS'(1);
            REQ_TICK_DN: begin
                start_amt = AMOUNT_BITS'(1);
                start_up  = 1'b0;
            end
            REQ_ADD:     start_amt = amount;
            REQ_SUB: begin
                start_amt = amount;
                start_up  = 1'b0;
            end
            default:     start_amt = '0;
        endcase
    end

    rcc_step #(.AMOUNT_BITS(AMOUNT_BITS)) u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .start_up  (start_up),
        .start_amt (start_amt),
        .advance   (advance),
        .step      (step),
        .last      (last)
    );

    // Gregorian leap year: divisible by 4, and by 16 when divisible by 25
    assign yr_mul = year_val * INV25_Y;
    assign leap   = (year_val[1:0] == 2'b00) && ((yr_mul > DIV25_LIM) || (year_val[3:0] == 4'h0));

    // stepping back from January lands in December, 31 days in any year
    assign prev_mon  = (mon_val == MON_JAN) ? MON_DEC : mon_val - MON_JAN;
    assign day_hi    = ctl_day.load ? DAY_MAX : days_in(mon_val, leap);
    assign day_hi_dn = days_in(prev_mon, leap);

    always_comb begin
        ctl_sec  = '0;
        ctl_min  = '0;
        ctl_hour = '0;
        ctl_day  = '0;
        ctl_mon  = '0;
        ctl_year = '0;

        ctl_sec.load  = is_load;
        ctl_min.load  = is_load;
        ctl_hour.load = is_load;
        ctl_day.load  = is_load;
        ctl_mon.load  = is_load;
        ctl_year.load = is_load;
        // day is loaded against 31 first, then clamped once month and year are held
        ctl_day.clamp = advance && load_reg;

        ctl_sec.inc  = do_step && step.up && step.lvl[LVL_SEC];
        ctl_sec.dec  = do_step && !step.up && step.lvl[LVL_SEC];
        ctl_min.inc  = (do_step && step.up && step.lvl[LVL_MIN]) || sec_cy;
        ctl_min.dec  = (do_step && !step.up && step.lvl[LVL_MIN]) || sec_bw;
        ctl_hour.inc = (do_step && step.up && step.lvl[LVL_HOUR]) || min_cy;
        ctl_hour.dec = (do_step && !step.up && step.lvl[LVL_HOUR]) || min_bw;
        ctl_day.inc  = (do_step && step.up && step.lvl[LVL_DAY]) || hour_cy;
        ctl_day.dec  = (do_step && !step.up && step.lvl[LVL_DAY]) || hour_bw;
        ctl_mon.inc  = day_cy;
        ctl_mon.dec  = day_bw;
        ctl_year.inc = mon_cy;
        ctl_year.dec = mon_bw;
    end

    rcc_cell #(.W(SEC_W), .RST_VAL('0)) u_sec (
        .aclk (aclk), .aresetn (aresetn), .ctl (ctl_sec), .load_val (in_second),
        .lo ('0), .hi (SEC_MAX), .hi_dn (SEC_MAX),
        .value (sec_val), .value_nxt (sec_nxt), .carry (sec_cy), .borrow (sec_bw)
    );

    rcc_cell #(.W(MIN_W), .RST_VAL('0)) u_min (
        .aclk (aclk), .aresetn (aresetn), .ctl (ctl_min), .load_val (in_minute),
        .lo ('0), .hi (MIN_MAX), .hi_dn (MIN_MAX),
        .value (min_val), .value_nxt (min_nxt), .carry (min_cy), .borrow (min_bw)
    );

    rcc_cell #(.W(HOUR_W), .RST_VAL('0)) u_hour (
        .aclk (aclk), .aresetn (aresetn), .ctl (ctl_hour), .load_val (in_hour),
        .lo ('0), .hi (HOUR_MAX), .hi_dn (HOUR_MAX),
        .value (hour_val), .value_nxt (hour_nxt), .carry (hour_cy), .borrow (hour_bw)
    );

    rcc_cell #(.W(DAY_W), .RST_VAL(DAY_MIN)) u_day (
        .aclk (aclk), .aresetn (aresetn), .ctl (ctl_day), .load_val (in_day),
        .lo (DAY_MIN), .hi (day_hi), .hi_dn (day_hi_dn),
        .value (day_val), .value_nxt (day_nxt), .carry (day_cy), .borrow (day_bw)
    );

    rcc_cell #(.W(MON_W), .RST_VAL(MON_JAN)) u_mon (
        .aclk (aclk), .aresetn (aresetn), .ctl (ctl_mon), .load_val (in_month),
        .lo (MON_JAN), .hi (MON_DEC), .hi_dn (MON_DEC),
        .value (mon_val), .value_nxt (mon_nxt), .carry (mon_cy), .borrow (mon_bw)
    );

    rcc_cell #(.W(YEAR_BITS), .RST_VAL(YEAR_RST)) u_year (
        .aclk (aclk), .aresetn (aresetn), .ctl (ctl_year), .load_val (in_year),
        .lo ('0), .hi ('1), .hi_dn ('1),
        .value (year_val), .value_nxt (year_nxt), .carry (year_cy), .borrow (year_bw)
    );

    assign wrap_now = year_cy || year_bw;

    // fields compared as given, year first
    assign cmp_less = {year_val, mon_val, day_val, hour_val, min_val, sec_val}
                    < {in_year, in_month, in_day, in_hour, in_minute, in_second};
    assign cmp_eq   = {year_val, mon_val, day_val, hour_val, min_val, sec_val}
                   == {in_year, in_month, in_day, in_hour, in_minute, in_second};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_BUSY;
            ST_BUSY: if (finish) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            load_reg     <= 1'b0;
            less_reg     <= 1'b0;
            eq_reg       <= 1'b0;
            wrap_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                load_reg <= (req == REQ_LOAD);
                less_reg <= (req == REQ_CMP) && cmp_less;
                eq_reg   <= (req == REQ_CMP) && cmp_eq;
                wrap_reg <= 1'b0;
            end else if (do_step && wrap_now) begin
                wrap_reg <= 1'b1;
            end
            if (finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // capture the values the last step leaves behind
    always_ff @(posedge aclk) begin
        if (finish) begin
            m_tdata_reg <= M_W'({wrap_reg || wrap_now, eq_reg, less_reg,
                                 year_nxt, mon_nxt, day_nxt, hour_nxt, min_nxt, sec_nxt});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### hdl/rcc_checker.sv
// Port-level checker for the calendar clock counter, bound to the top level.
// Depends on rcc_pkg and calendar_clock_counter_unit_macros.svh.
`include "calendar_clock_counter_unit_macros.svh"

module rcc_checker #(
    parameter int YEAR_BITS   = rcc_pkg::YEAR_BITS_DEF,
    parameter int AMOUNT_BITS = rcc_pkg::AMOUNT_BITS_DEF
) (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic [((AMOUNT_BITS + rcc_pkg::DATE_FIX_BITS + YEAR_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input logic [rcc_pkg::REQ_W-1:0] s_tuser,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((rcc_pkg::DATE_FIX_BITS + YEAR_BITS + rcc_pkg::FLAG_BITS + 7) / 8) * 8 - 1:0]
        m_tdata
);
    import rcc_pkg::*;

    localparam int O_MIN  = SEC_W;
    localparam int O_HOUR = O_MIN + MIN_W;
    localparam int O_DAY  = O_HOUR + HOUR_W;
    localparam int O_MON  = O_DAY + DAY_W;
    localparam int O_LESS = O_MON + MON_W + YEAR_BITS;
    localparam int O_EQ   = O_LESS + 1;
    localparam int O_WRAP = O_EQ + 1;

    logic [SEC_W-1:0]  o_sec;
    logic [MIN_W-1:0]  o_min;
    logic [HOUR_W-1:0] o_hour;
    logic [DAY_W-1:0]  o_day;
    logic [MON_W-1:0]  o_mon;
    logic              o_less;
    logic              o_eq;
    logic              o_wrap;
    logic              time_ok;
    logic              date_ok;
    logic              in_seen;

    assign o_sec   = m_tdata[SEC_W-1:0];
    assign o_min   = m_tdata[O_MIN +: MIN_W];
    assign o_hour  = m_tdata[O_HOUR +: HOUR_W];
    assign o_day   = m_tdata[O_DAY +: DAY_W];
    assign o_mon   = m_tdata[O_MON +: MON_W];
    assign o_less  = m_tdata[O_LESS];
    assign o_eq    = m_tdata[O_EQ];
    assign o_wrap  = m_tdata[O_WRAP];
    assign time_ok = (o_sec <= SEC_MAX) && (o_min <= MIN_MAX) && (o_hour <= HOUR_MAX);
    assign date_ok = (o_day >= DAY_MIN) && (o_day <= DAY_MAX)
                  && (o_mon >= MON_JAN) && (o_mon <= MON_DEC);
    // payload and kind are only looked at through the handshake
    assign in_seen = s_tvalid && s_tready && ((^s_tdata) || !(^s_tdata) || (s_tuser != '0)
                                              || (s_tuser == '0));

    `RCC_ASSERT_ANY(a_reset_clears_out, !aresetn |=> !m_tvalid, "result valid right after reset")
    `RCC_ASSERT(a_one_at_a_time, in_seen |=> !s_tready, "second transfer taken while busy")
    `RCC_ASSERT(a_held_date_valid, m_tvalid |-> time_ok && date_ok, "result date out of range")
    `RCC_ASSERT(a_flags_exclusive, m_tvalid |-> !(o_less && o_eq) && !(o_wrap && (o_less || o_eq)),
        "result flags conflict")
    `RCC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
        "stalled result changed")

endmodule

bind calendar_clock_counter_unit rcc_checker #(
    .YEAR_BITS   (YEAR_BITS),
    .AMOUNT_BITS (AMOUNT_BITS)
) u_rcc_checker (.*);
